// ----- hw/rtl/y86sp_pkg.sv -----
// ----------------------------------------------------------------------------
// Y86-64 sequential processor package
// Shared types, codes and helper functions for the processor block.
// ----------------------------------------------------------------------------
package y86sp_pkg;

  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned RF_DEPTH  = 16;
  localparam int unsigned RF_AW     = $clog2(RF_DEPTH);

  localparam logic [1:0] ST_AOK = 2'd0;
  localparam logic [1:0] ST_HLT = 2'd1;
  localparam logic [1:0] ST_ADR = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  localparam logic [3:0] I_HALT   = 4'h0;
  localparam logic [3:0] I_NOP    = 4'h1;
  localparam logic [3:0] I_CMOV   = 4'h2;
  localparam logic [3:0] I_IRMOV  = 4'h3;
  localparam logic [3:0] I_RMMOV  = 4'h4;
  localparam logic [3:0] I_MRMOV  = 4'h5;
  localparam logic [3:0] I_OP     = 4'h6;
  localparam logic [3:0] I_JXX    = 4'h7;
  localparam logic [3:0] I_CALL   = 4'h8;
  localparam logic [3:0] I_RET    = 4'h9;
  localparam logic [3:0] I_PUSH   = 4'ha;
  localparam logic [3:0] I_POP    = 4'hb;

  localparam logic [3:0] RSP_ID = 4'd4;
  localparam logic [3:0] NO_REG = 4'd15;

  localparam logic [3:0] MAX_OP_FN   = 4'd3;
  localparam logic [3:0] MAX_COND_FN = 4'd6;

  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_SUB = 2'd1,
    FN_AND = 2'd2,
    FN_XOR = 2'd3
  } alu_fn_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_FOP,
    S_FOPW,
    S_FREG,
    S_FREGW,
    S_FC,
    S_FCW,
    S_RA,
    S_RAW,
    S_RB,
    S_RBW,
    S_RSP,
    S_RSPW,
    S_EXEC,
    S_DRD,
    S_DRDW,
    S_DWR,
    S_WB1,
    S_WB2,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [11:0] load_addr;
    logic [7:0]  load_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] pc_now;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;
    logic        reg_wrote;
    logic [3:0]  reg_dest;
    logic [63:0] reg_value;
    logic        mem_wrote;
    logic [11:0] mem_addr;
    logic [63:0] mem_value;
  } out_item_t;

  typedef struct packed {
    logic [63:0] res;
    logic        zf;
    logic        sf;
    logic        of;
  } alu_out_t;

  // Branch and move conditions from ZF, SF and OF.
  function automatic logic cond_true(input logic [3:0] fn, input logic zf,
                                     input logic sf, input logic of);
    logic lt;
    lt = sf ^ of;
    case (fn)
      4'd0:    cond_true = 1'b1;
      4'd1:    cond_true = lt | zf;
      4'd2:    cond_true = lt;
      4'd3:    cond_true = zf;
      4'd4:    cond_true = ~zf;
      4'd5:    cond_true = ~lt;
      default: cond_true = ~lt & ~zf;
    endcase
  endfunction

  // A quad word access must lie entirely inside memory.
  function automatic logic quad_ok(input logic [63:0] a);
    quad_ok = (a <= 64'(MEM_BYTES - 8));
  endfunction

endpackage

// ----- hw/rtl/y86sp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module y86sp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/y86sp_alu.sv -----
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// 64-bit add, subtract, and, xor with condition flags.
// ----------------------------------------------------------------------------
module y86sp_alu (
  input  logic [63:0]             a_i,
  input  logic [63:0]             b_i,
  input  y86sp_pkg::alu_fn_e      fn_i,
  output y86sp_pkg::alu_out_t     res_o
);
  import y86sp_pkg::*;

  logic [63:0] res;
  logic        of;

  always_comb begin
    of = 1'b0;
    case (fn_i)
      FN_ADD: begin
        res = b_i + a_i;
        of  = (a_i[63] == b_i[63]) && (res[63] != b_i[63]);
      end
      FN_SUB: begin
        res = b_i - a_i;
        of  = (a_i[63] != b_i[63]) && (res[63] != b_i[63]);
      end
      FN_AND:  res = b_i & a_i;
      default: res = b_i ^ a_i;
    endcase
  end

  assign res_o.res = res;
  assign res_o.zf  = (res == 64'd0);
  assign res_o.sf  = res[63];
  assign res_o.of  = of;

endmodule

// ----- hw/rtl/y86_sequential_processor_top.sv -----
// ----------------------------------------------------------------------------
// Y86-64 sequential processor
// Byte memory, register file and a sequencer around one shared ALU.
// ----------------------------------------------------------------------------
// After reset the block clears memory and registers and takes no transaction
// until then. A load transaction writes its byte and then presents the result
// in the output state. A step transaction runs one instruction and ends in the
// output state; mrmovq takes the longest, and a fault found at fetch ends the
// step before any register is read. Every byte goes through the single-port
// byte memory with a registered read. The three register operands are read one
// by one from a single-port register RAM. All 64-bit arithmetic goes through
// one shared unit; byte offsets and the fetch bound check use separate adders.
module y86_sequential_processor_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  y86sp_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output y86sp_pkg::out_item_t out_data_o
);
  import y86sp_pkg::*;

  state_e      state_q, state_d;
  logic [MEM_AW-1:0] clr_q, clr_d;
  logic [63:0] pc_q, pc_d;
  logic        zf_q, zf_d, sf_q, sf_d, of_q, of_d;
  logic [1:0]  stat_q, stat_d;
  logic [3:0]  icode_q, icode_d, ifun_q, ifun_d, ra_q, ra_d, rb_q, rb_d;
  logic        nr_q, nr_d, nc_q, nc_d;
  logic [63:0] valc_q, valc_d, vala_q, vala_d, valb_q, valb_d;
  logic [63:0] rsp_q, rsp_d, valp_q, valp_d, addr_q, addr_d, data_q, data_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        rw_q, rw_d, mw_q, mw_d;
  logic [3:0]  rdest_q, rdest_d;
  logic [63:0] rval_q, rval_d, mval_q, mval_d;
  logic [11:0] maddr_q, maddr_d;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              rf_we;
  logic [RF_AW-1:0]  rf_addr;
  logic [63:0]       rf_wdata, rf_rdata;

  logic [63:0] alu_a, alu_b;
  alu_fn_e     alu_fn;
  alu_out_t    alu_o;

  y86sp_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  y86sp_ram #(.WIDTH(64), .DEPTH(RF_DEPTH)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .addr_i  (rf_addr),
    .wdata_i (rf_wdata),
    .rdata_o (rf_rdata)
  );

  y86sp_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .fn_i  (alu_fn),
    .res_o (alu_o)
  );

  // Decode of the opcode byte as it comes out of memory.
  logic [3:0]  dec_icode, dec_ifun, dec_len;
  logic        dec_bad, dec_nr, dec_nc, dec_oob;
  logic [12:0] dec_end;
  assign dec_icode = mem_rdata[7:4];
  assign dec_ifun  = mem_rdata[3:0];
  assign dec_bad   = (dec_icode > I_POP) ||
                     ((dec_icode == I_OP) && (dec_ifun > MAX_OP_FN)) ||
                     (((dec_icode == I_CMOV) || (dec_icode == I_JXX)) &&
                      (dec_ifun > MAX_COND_FN));
  assign dec_nr    = (dec_icode == I_CMOV) || (dec_icode == I_IRMOV) ||
                     (dec_icode == I_RMMOV) || (dec_icode == I_MRMOV) ||
                     (dec_icode == I_OP) || (dec_icode == I_PUSH) ||
                     (dec_icode == I_POP);
  assign dec_nc    = (dec_icode == I_IRMOV) || (dec_icode == I_RMMOV) ||
                     (dec_icode == I_MRMOV) || (dec_icode == I_JXX) ||
                     (dec_icode == I_CALL);
  assign dec_len   = 4'd1 + (dec_nr ? 4'd1 : 4'd0) + (dec_nc ? 4'd8 : 4'd0);
  assign dec_end   = {1'b0, pc_q[MEM_AW-1:0]} + 13'(dec_len);
  assign dec_oob   = dec_end > 13'(MEM_BYTES);

  logic        cond, pc_oob, stack_rd, addr_ok;
  logic [63:0] exec_addr;
  logic [MEM_AW-1:0] fetch_base;
  assign cond       = cond_true(ifun_q, zf_q, sf_q, of_q);
  assign pc_oob     = (pc_q >= 64'(MEM_BYTES));
  assign stack_rd   = (icode_q == I_RET) || (icode_q == I_POP);
  assign exec_addr  = stack_rd ? rsp_q : alu_o.res;
  assign addr_ok    = quad_ok(exec_addr);
  assign fetch_base = pc_q[MEM_AW-1:0] + MEM_AW'(1) + (nr_q ? MEM_AW'(1) : MEM_AW'(0));

  // ALU operand selection.
  always_comb begin
    alu_a  = valc_q;
    alu_b  = valb_q;
    alu_fn = FN_ADD;
    case (state_q)
      S_FOPW: begin
        alu_a = 64'(dec_len);
        alu_b = pc_q;
      end
      S_EXEC: begin
        if (icode_q == I_OP) begin
          alu_a  = vala_q;
          alu_fn = alu_fn_e'(ifun_q[1:0]);
        end else if ((icode_q == I_CALL) || (icode_q == I_PUSH)) begin
          alu_a  = 64'd8;
          alu_b  = rsp_q;
          alu_fn = FN_SUB;
        end
      end
      S_WB1: begin
        alu_a = 64'd8;
        alu_b = addr_q;
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == {MEM_AW{1'b1}}) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_data_i.kind || (stat_q != ST_AOK)) state_d = S_OUT;
          else                                       state_d = S_FOP;
        end
      end
      S_FOP:   state_d = pc_oob ? S_OUT : S_FOPW;
      S_FOPW: begin
        if (dec_bad || dec_oob) state_d = S_OUT;
        else if (dec_nr)        state_d = S_FREG;
        else if (dec_nc)        state_d = S_FC;
        else                    state_d = S_RA;
      end
      S_FREG:  state_d = S_FREGW;
      S_FREGW: state_d = nc_q ? S_FC : S_RA;
      S_FC:    state_d = S_FCW;
      S_FCW:   state_d = (cnt_q == 3'd7) ? S_RA : S_FC;
      S_RA:    state_d = S_RAW;
      S_RAW:   state_d = S_RB;
      S_RB:    state_d = S_RBW;
      S_RBW:   state_d = S_RSP;
      S_RSP:   state_d = S_RSPW;
      S_RSPW:  state_d = S_EXEC;
      S_EXEC: begin
        case (icode_q)
          I_RMMOV, I_CALL, I_PUSH: state_d = addr_ok ? S_DWR : S_OUT;
          I_MRMOV, I_RET, I_POP:   state_d = addr_ok ? S_DRD : S_OUT;
          default:                 state_d = S_OUT;
        endcase
      end
      S_DRD:   state_d = S_DRDW;
      S_DRDW:  state_d = (cnt_q == 3'd7) ? S_WB1 : S_DRD;
      S_DWR:   state_d = (cnt_q == 3'd7) ? S_OUT : S_DWR;
      S_WB1:   state_d = (icode_q == I_POP) ? S_WB2 : S_OUT;
      S_WB2:   state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    clr_d   = clr_q;
    pc_d    = pc_q;
    zf_d    = zf_q;
    sf_d    = sf_q;
    of_d    = of_q;
    stat_d  = stat_q;
    icode_d = icode_q;
    ifun_d  = ifun_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    nr_d    = nr_q;
    nc_d    = nc_q;
    valc_d  = valc_q;
    vala_d  = vala_q;
    valb_d  = valb_q;
    rsp_d   = rsp_q;
    valp_d  = valp_q;
    addr_d  = addr_q;
    data_d  = data_q;
    cnt_d   = cnt_q;
    rw_d    = rw_q;
    rdest_d = rdest_q;
    rval_d  = rval_q;
    mw_d    = mw_q;
    maddr_d = maddr_q;
    mval_d  = mval_q;
    mem_we    = 1'b0;
    mem_addr  = pc_q[MEM_AW-1:0];
    mem_wdata = data_q[7:0];
    rf_we     = 1'b0;
    rf_addr   = ra_q;
    rf_wdata  = alu_o.res;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = 8'd0;
        rf_we     = 1'b1;
        rf_addr   = clr_q[RF_AW-1:0];
        rf_wdata  = 64'd0;
        clr_d     = clr_q + MEM_AW'(1);
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        rw_d    = 1'b0;
        rdest_d = 4'd0;
        rval_d  = 64'd0;
        mw_d    = 1'b0;
        maddr_d = 12'd0;
        mval_d  = 64'd0;
        ra_d    = NO_REG;
        rb_d    = NO_REG;
        valc_d  = 64'd0;
        cnt_d   = 3'd0;
        if (in_valid_i && !in_data_i.kind) begin
          mem_we    = 1'b1;
          mem_addr  = in_data_i.load_addr[MEM_AW-1:0];
          mem_wdata = in_data_i.load_byte;
        end
      end
      S_FOP: begin
        if (pc_oob) stat_d = ST_ADR;
      end
      S_FOPW: begin
        icode_d = dec_icode;
        ifun_d  = dec_ifun;
        nr_d    = dec_nr;
        nc_d    = dec_nc;
        valp_d  = alu_o.res;
        if (dec_bad)      stat_d = ST_INS;
        else if (dec_oob) stat_d = ST_ADR;
      end
      S_FREG: mem_addr = pc_q[MEM_AW-1:0] + MEM_AW'(1);
      S_FREGW: begin
        ra_d = mem_rdata[7:4];
        rb_d = mem_rdata[3:0];
      end
      S_FC: mem_addr = fetch_base + MEM_AW'(cnt_q);
      S_FCW: begin
        valc_d = {mem_rdata, valc_q[63:8]};
        cnt_d  = cnt_q + 3'd1;
      end
      S_RA:   rf_addr = ra_q;
      S_RAW:  vala_d  = rf_rdata;
      S_RB:   rf_addr = rb_q;
      S_RBW:  valb_d  = rf_rdata;
      S_RSP:  rf_addr = RSP_ID;
      S_RSPW: rsp_d   = rf_rdata;
      S_EXEC: begin
        cnt_d  = 3'd0;
        addr_d = exec_addr;
        case (icode_q)
          I_HALT: begin
            pc_d   = valp_q;
            stat_d = ST_HLT;
          end
          I_CMOV: begin
            pc_d = valp_q;
            if (cond && (rb_q != NO_REG)) begin
              rf_we    = 1'b1;
              rf_addr  = rb_q;
              rf_wdata = vala_q;
              rw_d     = 1'b1;
              rdest_d  = rb_q;
              rval_d   = vala_q;
            end
          end
          I_IRMOV: begin
            pc_d = valp_q;
            if (rb_q != NO_REG) begin
              rf_we    = 1'b1;
              rf_addr  = rb_q;
              rf_wdata = valc_q;
              rw_d     = 1'b1;
              rdest_d  = rb_q;
              rval_d   = valc_q;
            end
          end
          I_OP: begin
            pc_d = valp_q;
            zf_d = alu_o.zf;
            sf_d = alu_o.sf;
            of_d = alu_o.of;
            if (rb_q != NO_REG) begin
              rf_we   = 1'b1;
              rf_addr = rb_q;
              rw_d    = 1'b1;
              rdest_d = rb_q;
              rval_d  = alu_o.res;
            end
          end
          I_JXX: pc_d = cond ? valc_q : valp_q;
          I_RMMOV, I_CALL, I_PUSH: begin
            if (!addr_ok) begin
              stat_d = ST_ADR;
            end else begin
              data_d  = (icode_q == I_CALL) ? valp_q : vala_q;
              mw_d    = 1'b1;
              maddr_d = exec_addr[11:0];
              mval_d  = (icode_q == I_CALL) ? valp_q : vala_q;
              if (icode_q != I_RMMOV) begin
                // The stack pointer moves down before the store goes out.
                rf_we   = 1'b1;
                rf_addr = RSP_ID;
                rw_d    = 1'b1;
                rdest_d = RSP_ID;
                rval_d  = alu_o.res;
              end
            end
          end
          I_MRMOV, I_RET, I_POP: begin
            if (!addr_ok) stat_d = ST_ADR;
          end
          default: pc_d = valp_q;
        endcase
      end
      S_DRD: mem_addr = addr_q[MEM_AW-1:0] + MEM_AW'(cnt_q);
      S_DRDW: begin
        data_d = {mem_rdata, data_q[63:8]};
        cnt_d  = cnt_q + 3'd1;
      end
      S_DWR: begin
        mem_we    = 1'b1;
        mem_addr  = addr_q[MEM_AW-1:0] + MEM_AW'(cnt_q);
        mem_wdata = data_q[7:0];
        data_d    = {8'd0, data_q[63:8]};
        cnt_d     = cnt_q + 3'd1;
        if (cnt_q == 3'd7) pc_d = (icode_q == I_CALL) ? valc_q : valp_q;
      end
      S_WB1: begin
        if (icode_q == I_MRMOV) begin
          pc_d = valp_q;
          if (ra_q != NO_REG) begin
            rf_we    = 1'b1;
            rf_addr  = ra_q;
            rf_wdata = data_q;
            rw_d     = 1'b1;
            rdest_d  = ra_q;
            rval_d   = data_q;
          end
        end else begin
          rf_we   = 1'b1;
          rf_addr = RSP_ID;
          rw_d    = 1'b1;
          rdest_d = RSP_ID;
          rval_d  = alu_o.res;
          if (icode_q == I_RET) pc_d = data_q;
        end
      end
      S_WB2: begin
        pc_d = valp_q;
        if (ra_q != NO_REG) begin
          rf_we    = 1'b1;
          rf_addr  = ra_q;
          rf_wdata = data_q;
          rw_d     = 1'b1;
          rdest_d  = ra_q;
          rval_d   = data_q;
        end
      end
      S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pc_q    <= 64'd0;
      zf_q    <= 1'b0;
      sf_q    <= 1'b0;
      of_q    <= 1'b0;
      stat_q  <= ST_AOK;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pc_q    <= pc_d;
      zf_q    <= zf_d;
      sf_q    <= sf_d;
      of_q    <= of_d;
      stat_q  <= stat_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    icode_q <= icode_d;
    ifun_q  <= ifun_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    nr_q    <= nr_d;
    nc_q    <= nc_d;
    valc_q  <= valc_d;
    vala_q  <= vala_d;
    valb_q  <= valb_d;
    rsp_q   <= rsp_d;
    valp_q  <= valp_d;
    addr_q  <= addr_d;
    data_q  <= data_d;
    rw_q    <= rw_d;
    rdest_q <= rdest_d;
    rval_q  <= rval_d;
    mw_q    <= mw_d;
    maddr_q <= maddr_d;
    mval_q  <= mval_d;
  end

  assign out_data_o.status        = stat_q;
  assign out_data_o.pc_now        = pc_q[11:0];
  assign out_data_o.zero_flag     = zf_q;
  assign out_data_o.sign_flag     = sf_q;
  assign out_data_o.overflow_flag = of_q;
  assign out_data_o.reg_wrote     = rw_q;
  assign out_data_o.reg_dest      = rdest_q;
  assign out_data_o.reg_value     = rval_q;
  assign out_data_o.mem_wrote     = mw_q;
  assign out_data_o.mem_addr      = maddr_q;
  assign out_data_o.mem_value     = mval_q;

endmodule
